[rtl/spimf_pkg.sv]
// Package with register offsets, field widths and action codes for the SPI master.
`default_nettype none
package spimf_pkg;
   localparam int FIFO_DEPTH_DEF     = 16;
   localparam int MAX_WORD_BITS_DEF  = 16;
   localparam int CS_CTRL_OFFSET_DEF = 548;

   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;

   localparam logic [9:0] OFF_CTRL0  = 10'h000;
   localparam logic [9:0] OFF_CTRL1  = 10'h004;
   localparam logic [9:0] OFF_STATUS = 10'h008;
   localparam logic [9:0] OFF_DATA   = 10'h010;

   typedef struct packed {
      logic [1:0]  action;
      logic [9:0]  reg_offset;
      logic [31:0] write_data;
      logic        miso;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        sclk;
      logic        mosi;
      logic        cs_n;
      logic        irq;
   } rsp_type;
endpackage
`default_nettype wire

[rtl/spimf_fifo.sv]
// Circular FIFO with count, one push and one pop per cycle.
`default_nettype none
module spimf_fifo #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] head,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [PW-1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
      nxt = (p == PW'(DEPTH-1)) ? '0 : p + PW'(1);
   endfunction

   always_comb begin
      rd_in  = pop ? nxt(rd_ff) : rd_ff;
      wr_in  = push ? nxt(wr_ff) : wr_ff;
      cnt_in = cnt_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_data;
      end
   end

   assign head  = mem[rd_ff];
   assign count = cnt_ff;
endmodule
`default_nettype wire

[rtl/spi_master_with_fifos_core.sv]
// Top level: request register, SPI register map, shifter, FIFOs and response register.
// An accepted request waits in the request register, then its response is registered.
// Throughput: one request per cycle; the request register takes the next
// request while the current response waits, stalling only when both are full.
// Reset (synchronous, active high) clears control fields, empties both FIFOs,
// stops the shifter and sets chip select to software mode, level high.
`default_nettype none
module spi_master_with_fifos_core
   import spimf_pkg::*;
#(
   parameter int FIFO_DEPTH     = FIFO_DEPTH_DEF,
   parameter int MAX_WORD_BITS  = MAX_WORD_BITS_DEF,
   parameter int CS_CTRL_OFFSET = CS_CTRL_OFFSET_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] action, [11:2] reg_offset, [43:12] write_data, [44] miso, zero pad
   input  wire logic [47:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [31:0] read_data, [32] sclk, [33] mosi, [34] cs_n, [35] irq, zero pad
   output logic      [39:0] rsp_tdata
);
   localparam int CW = $clog2(FIFO_DEPTH+1);
   localparam int WB = MAX_WORD_BITS;
   localparam int BW = $clog2(MAX_WORD_BITS+1);
   localparam int SW = $clog2(MAX_WORD_BITS);
   localparam logic [9:0] OFF_CS = 10'(CS_CTRL_OFFSET) & 10'h3fc;

   logic        in_v_ff;
   logic [1:0]  act_ff;
   logic [9:0]  off_ff;
   logic [31:0] wd_ff;
   logic        miso_ff;
   logic        out_v_ff;
   rsp_type     out_ff, out_in;
   logic        advance;

   logic [11:0] div_ff;
   logic        en_ff;
   logic [3:0]  wbm_ff;
   logic [1:0]  ff_ff;
   logic [2:0]  ien_ff;
   logic [7:0]  thr_ff;
   logic [1:0]  cm_ff;
   logic [1:0]  cs_ff;
   logic [WB-1:0] sh_ff;
   logic [BW-1:0] bl_ff;
   logic [11:0] tc_ff;

   logic [11:0] div_in;
   logic        en_in;
   logic [3:0]  wbm_in;
   logic [1:0]  ff_in;
   logic [2:0]  ien_in;
   logic [7:0]  thr_in;
   logic [1:0]  cm_in;
   logic [1:0]  cs_in;
   logic [WB-1:0] sh_in;
   logic [BW-1:0] bl_in;
   logic [11:0] tc_in;

   logic          tx_push, tx_pop, rx_push, rx_pop;
   logic [WB-1:0] tx_head, rx_head, rx_wdata;
   logic [CW-1:0] tx_cnt, rx_cnt, tx_cnt2, rx_cnt2;
   logic [31:0]   rd;

   assign advance    = in_v_ff && (!out_v_ff || rsp_tready);
   assign req_tready = !in_v_ff || advance;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {4'd0, out_ff.irq, out_ff.cs_n, out_ff.mosi, out_ff.sclk,
                        out_ff.read_data};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_v_ff <= req_tvalid;
         end
         if (advance) begin
            out_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         act_ff  <= req_tdata[1:0];
         off_ff  <= req_tdata[11:2] & 10'h3fc;
         wd_ff   <= req_tdata[43:12];
         miso_ff <= req_tdata[44];
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   spimf_fifo #(.DEPTH(FIFO_DEPTH), .WIDTH(WB)) u_tx (
      .clock(clock), .reset(reset), .push(tx_push & advance), .push_data(wd_ff[WB-1:0]),
      .pop(tx_pop & advance), .head(tx_head), .count(tx_cnt)
   );
   spimf_fifo #(.DEPTH(FIFO_DEPTH), .WIDTH(WB)) u_rx (
      .clock(clock), .reset(reset), .push(rx_push & advance), .push_data(rx_wdata),
      .pop(rx_pop & advance), .head(rx_head), .count(rx_cnt)
   );

   always_comb begin
      logic [BW-1:0] n;
      logic [5:0]    nw;
      logic [SW-1:0] pos;
      logic [12:0]   p;
      logic          lead, busy, tsv, rsv;
      div_in = div_ff; en_in = en_ff; wbm_in = wbm_ff; ff_in = ff_ff;
      ien_in = ien_ff; thr_in = thr_ff; cm_in = cm_ff; cs_in = cs_ff;
      sh_in = sh_ff; bl_in = bl_ff; tc_in = tc_ff;
      tx_push = 1'b0; tx_pop = 1'b0; rx_push = 1'b0; rx_pop = 1'b0;
      rx_wdata = sh_ff;
      rd = '0;
      nw = 6'(wbm_ff) + 6'd1;
      n = (nw > 6'(WB)) ? BW'(WB) : BW'(nw);
      pos = '0;
      p = '0;
      lead = 1'b0;
      case (act_ff)
         ACT_TICK: begin
            if (en_ff) begin
               if (bl_ff != '0) begin
                  if (tc_ff >= div_ff) begin
                     pos = SW'(bl_ff - BW'(1));
                     sh_in[pos] = miso_ff;
                     bl_in = bl_ff - BW'(1);
                     tc_in = '0;
                     rx_wdata = sh_in;
                     if (bl_in == '0 && rx_cnt < CW'(FIFO_DEPTH)) begin
                        rx_push = 1'b1;
                     end
                  end else begin
                     tc_in = tc_ff + 12'd1;
                  end
               end
               if (bl_in == '0 && tx_cnt != '0) begin
                  tx_pop = 1'b1;
                  for (int i = 0; i < WB; i++) begin
                     sh_in[i] = tx_head[i] & (BW'(i) < n);
                  end
                  bl_in = n;
                  tc_in = '0;
               end
            end
         end
         ACT_READ: begin
            busy = bl_ff != '0 || (en_ff && tx_cnt != '0);
            tsv = en_ff && 32'(tx_cnt) <= 32'(thr_ff[3:0]);
            rsv = en_ff && 32'(rx_cnt) > 32'(thr_ff[7:4]);
            if (off_ff == OFF_CTRL0) begin
               rd = {12'd0, div_ff, en_ff, 1'b0, ff_ff, wbm_ff};
            end else if (off_ff == OFF_CTRL1) begin
               rd = {12'd0, ien_ff[2], 5'd0, thr_ff[7:4], thr_ff[3:0], 1'b0,
                     cm_ff[0], cm_ff[1], 1'b0, ien_ff[1:0]};
            end else if (off_ff == OFF_STATUS) begin
               rd = {16'd0, 4'(rx_cnt), 4'(tx_cnt), 1'b0, rsv, tsv, busy,
                     rx_cnt != '0, tx_cnt < CW'(FIFO_DEPTH), 2'd0};
            end else if (off_ff == OFF_DATA) begin
               if (rx_cnt != '0) begin
                  rd = 32'(rx_head);
                  rx_pop = 1'b1;
               end
            end else if (off_ff == OFF_CS) begin
               rd = {30'd0, cs_ff};
            end
         end
         ACT_WRITE: begin
            if (off_ff == OFF_CTRL0) begin
               wbm_in = wd_ff[3:0];
               ff_in  = wd_ff[5:4];
               en_in  = wd_ff[7];
               div_in = wd_ff[19:8];
               if (!wd_ff[7]) begin
                  bl_in = '0;
                  tc_in = '0;
               end
            end else if (off_ff == OFF_CTRL1) begin
               ien_in = {wd_ff[19], wd_ff[1:0]};
               cm_in  = {wd_ff[3], wd_ff[4]};
               thr_in = {wd_ff[13:10], wd_ff[9:6]};
            end else if (off_ff == OFF_DATA) begin
               tx_push = tx_cnt < CW'(FIFO_DEPTH);
            end else if (off_ff == OFF_CS) begin
               cs_in = wd_ff[1:0];
            end
         end
         default: begin
         end
      endcase

      tx_cnt2 = tx_cnt + CW'(tx_push) - CW'(tx_pop);
      rx_cnt2 = rx_cnt + CW'(rx_push) - CW'(rx_pop);
      out_in.read_data = rd;
      out_in.sclk = cm_in[1];
      out_in.mosi = 1'b0;
      if (bl_in != '0) begin
         p = {1'b0, div_in} + 13'd1;
         lead = {1'b0, tc_in} < (p - (p >> 1));
         out_in.sclk = cm_in[1] ^ (cm_in[0] ? lead : !lead);
         out_in.mosi = sh_in[SW'(bl_in - BW'(1))];
      end
      busy = bl_in != '0 || (en_in && tx_cnt2 != '0);
      out_in.cs_n = cs_in[0] ? cs_in[1] : !busy;
      tsv = en_in && 32'(tx_cnt2) <= 32'(thr_in[3:0]);
      rsv = en_in && 32'(rx_cnt2) > 32'(thr_in[7:4]);
      out_in.irq = (ien_in[1] && tsv) || (ien_in[0] && rsv);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff <= '0; en_ff <= 1'b0; wbm_ff <= '0; ff_ff <= '0;
         ien_ff <= '0; thr_ff <= '0; cm_ff <= '0; cs_ff <= 2'b11;
         sh_ff <= '0; bl_ff <= '0; tc_ff <= '0;
      end else if (advance) begin
         div_ff <= div_in; en_ff <= en_in; wbm_ff <= wbm_in; ff_ff <= ff_in;
         ien_ff <= ien_in; thr_ff <= thr_in; cm_ff <= cm_in; cs_ff <= cs_in;
         sh_ff <= sh_in; bl_ff <= bl_in; tc_ff <= tc_in;
      end
   end
endmodule
`default_nettype wire

[rtl/spimf_checker.sv]
// Port checker for the SPI master core, bound to the top level.
`default_nettype none
module spimf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);
   a_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response changed while stalled");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:36] == 4'd0)
      else $error("response padding not zero");
   a_resp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> ##1 rsp_tvalid)
      else $error("request without response");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output");
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");
endmodule

bind spi_master_with_fifos_core spimf_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire

[tb/spimf_checker.sv]
// Checker: watches the request and response channels, predicts SPI master outputs and compares.
`default_nettype none
module spimf_scoreboard
   import spimf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [47:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,
   output int               fail_count,
   output int               pending_count,
   output int               rsp_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [9:0] OFF_CS = 10'(CS_CTRL_OFFSET_DEF) & 10'h3fc;

   logic [11:0] divider;
   logic        enable;
   logic [3:0]  wbits_m1;
   logic [1:0]  frame_fmt;
   logic [2:0]  irq_en;
   logic [7:0]  thresh;
   logic [1:0]  clk_mode;
   logic [15:0] tx_mem [16];
   logic [15:0] rx_mem [16];
   int          tx_rd, tx_wr, tx_cnt, rx_rd, rx_wr, rx_cnt;
   logic [15:0] shreg;
   int          bits_left;
   logic [11:0] tick_cnt;
   logic [1:0]  cs_ctrl;
   logic [39:0] expected_rsp [$];

   function automatic bit spi_busy();
      return bits_left != 0 || (enable && tx_cnt != 0);
   endfunction

   function automatic bit tx_req();
      return enable && tx_cnt <= int'(thresh[3:0]);
   endfunction

   function automatic bit rx_req();
      return enable && rx_cnt > int'(thresh[7:4]);
   endfunction

   task automatic model_reset();
      divider = '0; enable = 0; wbits_m1 = '0; frame_fmt = '0;
      irq_en = '0; thresh = '0; clk_mode = '0;
      tx_rd = 0; tx_wr = 0; tx_cnt = 0; rx_rd = 0; rx_wr = 0; rx_cnt = 0;
      shreg = '0; bits_left = 0; tick_cnt = '0; cs_ctrl = 2'b11;
   endtask

   task automatic spi_tick(input logic miso);
      int n;
      if (!enable) return;
      if (bits_left != 0) begin
         if (tick_cnt >= divider) begin
            shreg[bits_left-1] = miso;
            bits_left--;
            tick_cnt = '0;
            if (bits_left == 0 && rx_cnt < 16) begin
               rx_mem[rx_wr] = shreg;
               rx_wr = (rx_wr + 1) % 16;
               rx_cnt++;
            end
         end else begin
            tick_cnt = tick_cnt + 12'd1;
         end
      end
      if (bits_left == 0 && tx_cnt != 0) begin
         n = int'(wbits_m1) + 1;
         shreg = tx_mem[tx_rd] & 16'((17'd1 << n) - 1);
         tx_rd = (tx_rd + 1) % 16;
         tx_cnt--;
         bits_left = n;
         tick_cnt = '0;
      end
   endtask

   task automatic predict_request(input logic [47:0] raw, output logic [39:0] rsp);
      req_type     rq;
      logic [9:0]  off;
      logic [31:0] rd, d;
      int          p;
      bit          lead, act;
      rsp_type     r;
      rq = req_type'({raw[44], raw[43:12], raw[11:2], raw[1:0]});
      rq.action = raw[1:0];
      rq.reg_offset = raw[11:2];
      rq.write_data = raw[43:12];
      rq.miso = raw[44];
      off = rq.reg_offset & 10'h3fc;
      d = rq.write_data;
      rd = '0;
      if (rq.action == ACT_TICK) begin
         spi_tick(rq.miso);
      end else if (rq.action == ACT_READ) begin
         if (off == OFF_CTRL0) begin
            rd = {12'd0, divider, enable, 1'b0, frame_fmt, wbits_m1};
         end else if (off == OFF_CTRL1) begin
            rd = '0;
            rd[1:0] = irq_en[1:0]; rd[3] = clk_mode[1]; rd[4] = clk_mode[0];
            rd[9:6] = thresh[3:0]; rd[13:10] = thresh[7:4]; rd[19] = irq_en[2];
         end else if (off == OFF_STATUS) begin
            rd[2] = tx_cnt < 16; rd[3] = rx_cnt != 0; rd[4] = spi_busy();
            rd[5] = tx_req(); rd[6] = rx_req();
            rd[11:8] = 4'(tx_cnt); rd[15:12] = 4'(rx_cnt);
         end else if (off == OFF_DATA) begin
            if (rx_cnt != 0) begin
               rd = {16'd0, rx_mem[rx_rd]};
               rx_rd = (rx_rd + 1) % 16;
               rx_cnt--;
            end
         end else if (off == OFF_CS) begin
            rd = {30'd0, cs_ctrl};
         end
      end else if (rq.action == ACT_WRITE) begin
         if (off == OFF_CTRL0) begin
            wbits_m1 = d[3:0]; frame_fmt = d[5:4]; enable = d[7]; divider = d[19:8];
            if (!enable) begin
               bits_left = 0; tick_cnt = '0;
            end
         end else if (off == OFF_CTRL1) begin
            irq_en = {d[19], d[1:0]}; clk_mode = {d[3], d[4]};
            thresh = {d[13:10], d[9:6]};
         end else if (off == OFF_DATA) begin
            if (tx_cnt < 16) begin
               tx_mem[tx_wr] = d[15:0];
               tx_wr = (tx_wr + 1) % 16;
               tx_cnt++;
            end
         end else if (off == OFF_CS) begin
            cs_ctrl = d[1:0];
         end
      end
      r.read_data = rd;
      r.sclk = clk_mode[1];
      r.mosi = 0;
      if (bits_left != 0) begin
         p = int'(divider) + 1;
         lead = int'(tick_cnt) < (p - p / 2);
         act = clk_mode[0] ? lead : !lead;
         r.sclk = clk_mode[1] ^ act;
         r.mosi = shreg[bits_left-1];
      end
      r.cs_n = cs_ctrl[0] ? cs_ctrl[1] : !spi_busy();
      r.irq = (irq_en[1] && tx_req()) || (irq_en[0] && rx_req());
      rsp = {4'd0, r.irq, r.cs_n, r.mosi, r.sclk, r.read_data};
   endtask

   task automatic report_mismatch(input string what, input logic [39:0] got,
                                  input logic [39:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      logic [39:0] want;
      logic [39:0] pred;
      if (reset) begin
         model_reset();
         expected_rsp.delete();
         fail_count <= 0;
         rsp_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count <= rsp_count + 1;
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected response", rsp_tdata, '0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_tdata[31:0] !== want[31:0])
                  report_mismatch("read_data", rsp_tdata, want);
               if (rsp_tdata[32] !== want[32]) report_mismatch("sclk", rsp_tdata, want);
               if (rsp_tdata[33] !== want[33]) report_mismatch("mosi", rsp_tdata, want);
               if (rsp_tdata[34] !== want[34]) report_mismatch("cs_n", rsp_tdata, want);
               if (rsp_tdata[35] !== want[35]) report_mismatch("irq", rsp_tdata, want);
            end
         end
         if (req_tvalid && req_tready) begin
            predict_request(req_tdata, pred);
            expected_rsp.push_back(pred);
         end
      end
      pending_count <= expected_rsp.size();
   end

   initial begin
      fail_count = 0;
      pending_count = 0;
      rsp_count = 0;
   end
endmodule
`default_nettype wire

[tb/testbench.sv]
// Testbench top: clock, reset, request stimulus, response stalls and the verdict.
`default_nettype none
module testbench;
   import spimf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [9:0] OFF_CS = 10'(CS_CTRL_OFFSET_DEF) & 10'h3fc;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   int          fail_count, pending_count, rsp_count;
   int          cycle_count = 0;
   int          req_sent = 0;
   int          rx_pushed = 0;

   always #5 clock = ~clock;

   spi_master_with_fifos_core DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   spimf_scoreboard checker_inst (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending_count(pending_count), .rsp_count(rsp_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver stall pattern: random stretches that are calm, lightly stalled, heavily stalled or alternating
   initial begin
      int mode;
      int len;
      forever begin
         mode = $urandom_range(0, 3);
         len = $urandom_range(5, 60);
         repeat (len) begin
            @(posedge clock);
            case (mode)
               0: rsp_tready <= 1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= ~rsp_tready;
            endcase
         end
      end
   end

   task automatic send_request(input logic [1:0] act, input logic [9:0] off,
                               input logic [31:0] data, input logic miso);
      @(posedge clock);
      req_tvalid <= 1;
      req_tdata <= {3'd0, miso, data, off, act};
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 0;
      req_sent++;
   endtask

   task automatic send_burst(input logic [1:0] act, input logic [9:0] off,
                             input logic [31:0] data, input logic miso);
      req_tvalid <= 1;
      req_tdata <= {3'd0, miso, data, off, act};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      req_sent++;
   endtask

   task automatic idle_gap();
      req_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   task automatic drain_wait();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0 || rsp_tvalid) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   function automatic logic [31:0] ctrl0_word(input int div, input bit en, input int wm1);
      logic [31:0] w;
      w = $urandom;
      w[3:0] = 4'(wm1);
      w[7] = en;
      w[19:8] = 12'(div);
      return w;
   endfunction

   task automatic random_request(input int bias);
      int          pick;
      logic [1:0]  act;
      logic [9:0]  off;
      logic [31:0] data;
      pick = $urandom_range(0, 99);
      data = $urandom;
      off = 10'($urandom) & 10'h3fc;
      if (pick < 60 - bias) begin
         act = ACT_TICK;
      end else if (pick < 72) begin
         act = ACT_WRITE; off = OFF_DATA;
      end else if (pick < 82) begin
         act = ACT_READ;
         case ($urandom_range(0, 3))
            0: off = OFF_DATA;
            1: off = OFF_STATUS;
            2: off = OFF_CTRL1;
            default: off = OFF_CS;
         endcase
      end else if (pick < 87) begin
         act = ACT_WRITE; off = OFF_CTRL1;
      end else if (pick < 89) begin
         act = ACT_WRITE; off = OFF_CS;
      end else if (pick < 91) begin
         act = ACT_WRITE; off = OFF_CTRL0;
         data = ctrl0_word($urandom_range(0, 3), $urandom_range(0, 7) != 0,
                           $urandom_range(0, 15));
      end else if (pick < 96) begin
         act = 2'($urandom_range(0, 3));
      end else begin
         act = 2'd3;
      end
      off = off | 10'($urandom_range(0, 3));
      send_burst(act, off, data, $urandom_range(0, 1));
   endtask

   initial begin
      int i, burst;
      repeat (7) @(posedge clock);
      reset <= 0;

      // directed part
      send_request(ACT_READ, OFF_CS, '0, 0);
      send_request(ACT_READ, OFF_DATA, '0, 0);
      send_request(ACT_WRITE, OFF_CTRL1, 32'hffff_ffff, 1);
      send_request(ACT_READ, OFF_CTRL1, '0, 0);
      send_request(ACT_WRITE, OFF_CTRL0, 32'hffff_ff7f, 0);
      send_request(ACT_READ, OFF_CTRL0, '0, 0);
      for (i = 0; i < 17; i++) send_request(ACT_WRITE, OFF_DATA, 32'hffff_0000 | i, 0);
      send_request(ACT_READ, OFF_STATUS, '0, 1);
      send_request(ACT_WRITE, OFF_CS, 32'h0, 0);
      send_request(ACT_WRITE, OFF_CTRL0, ctrl0_word(0, 1, 15), 0);
      send_request(ACT_WRITE, OFF_STATUS, 32'hffff_ffff, 0);
      send_request(2'd3, 10'h3ff, 32'hffff_ffff, 1);
      send_request(ACT_READ, 10'h3fc, 32'h0, 1);
      drain_wait();

      // shift bursts under several settings; most small dividers
      for (i = 0; i < 1450; ) begin
         if ($urandom_range(0, 9) == 0) begin
            drain_wait();
            send_burst(ACT_WRITE, OFF_CTRL0,
                       ctrl0_word($urandom_range(0, 9) == 0 ? 4095 : $urandom_range(0, 3),
                                  1, $urandom_range(0, 15)), 0);
            i++;
         end
         burst = $urandom_range(1, 30);
         repeat (burst) begin
            random_request(i > 1000 ? 20 : 0);
            i++;
         end
         if ($urandom_range(0, 2) != 0) idle_gap();
         if (i > 700 && i < 740) drain_wait();
      end
      send_burst(ACT_WRITE, OFF_CTRL0, ctrl0_word(4095, 0, 0), 0);
      drain_wait();
      repeat (20) @(posedge clock);
      $display("Sent %0d requests, checked %0d responses over %0d cycles",
               req_sent, rsp_count, cycle_count);
      $display("Covered ticks, register access, FIFO full/empty, chip select modes, irq");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
`default_nettype wire
